// File: src/arat_pkg.sv
// types and constants shared by the region attribute table
package arat_pkg;

    localparam int FIELD_BITS   = 48;
    localparam int MARK_BITS    = 4;
    localparam int IN_DATA_BITS = 104;
    localparam int OUT_DATA_BITS = 104;

    localparam int MK_VALID = 0;
    localparam int MK_PREF  = 1;
    localparam int MK_RO    = 2;
    localparam int MK_WO    = 3;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_SET_PREF   = 3'd2,
        OP_MARK_RO    = 3'd3,
        OP_MARK_WO    = 3'd4,
        OP_CLEAR_ADV  = 3'd5,
        OP_QUERY      = 3'd6,
        OP_CLEAR_ALL  = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_NOMATCH = 3'd1,
        STS_FULL    = 3'd2,
        STS_DUP     = 3'd3,
        STS_ZERO    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_FINISH,
        ST_REPLY
    } t_state;

endpackage

// File: src/address_region_attribute_table.sv
// region attribute table: memory scan lookup with read-modify-write of region marks
// flow: clear all goes from accept through a clearing pass over the marks to reply, a zero address
//   straight to reply, every other operation through one pass over the table memory and finish
// throughput: one operation at a time, set by the single read port scan of the table memories
// reset: synchronous active low; a marks clearing pass over all TABLE_ENTRIES entries follows,
//   during which no beat is accepted
module address_region_attribute_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address, region_length, flag_value
    input  logic [arat_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // opcode
    input  logic [2:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // found, found_base, found_length, is_prefetched, is_read_only, is_write_only, base_exact
    output logic [arat_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // status
    output logic [2:0]                           m_axis_tuser
);

    localparam int AW = ADDRESS_BITS;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int FB = arat_pkg::FIELD_BITS;
    localparam int MB = arat_pkg::MARK_BITS;

    logic [2*AW-1:0] mem_data  [TABLE_ENTRIES];
    logic [MB-1:0]   mem_marks [TABLE_ENTRIES];

    arat_pkg::t_state  r_state, n_state;
    arat_pkg::t_opcode r_op;
    logic [CW-1:0]     r_cnt;
    logic              r_op_pend;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_len;
    logic              r_flag;
    logic              r_zero;

    logic [2*AW-1:0]   r_rd_data;
    logic [MB-1:0]     r_rd_marks;

    logic              r_best_vld;
    logic [AW-1:0]     r_best_base;
    logic [AW-1:0]     r_best_len;
    logic [MB-1:0]     r_best_marks;
    logic [IW-1:0]     r_best_idx;
    logic              r_dup;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;
    logic              r_hit;

    logic              r_out_valid;
    logic [FB*2+5-1:0] r_out_data;
    arat_pkg::t_status r_out_status;

    logic              w_accept;
    logic              w_load;
    logic              w_clear_done;
    logic [AW-1:0]     w_in_addr;
    logic [AW-1:0]     w_in_len;
    logic [IW-1:0]     w_rd_idx;
    logic [IW-1:0]     w_scan_idx;
    logic [AW-1:0]     w_rd_base;
    logic [AW-1:0]     w_rd_len;
    logic              w_rd_valid;

    logic              w_dat_we;
    logic [IW-1:0]     w_dat_idx;
    logic              w_mk_we;
    logic [IW-1:0]     w_mk_idx;
    logic [MB-1:0]     w_mk_data;
    logic              w_rep_mk_we;
    logic [MB-1:0]     w_new_marks;

    arat_pkg::t_status n_status;
    logic              n_found;
    logic [FB-1:0]     n_base;
    logic [FB-1:0]     n_len;
    logic              n_pref;
    logic              n_ro;
    logic              n_wo;
    logic              n_exact;

    assign w_in_addr    = AW'(s_axis_tdata[FB-1:0]);
    assign w_in_len     = AW'(s_axis_tdata[2*FB-1:FB]);
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_load       = (r_state == arat_pkg::ST_REPLY) && (!r_out_valid || m_axis_tready);
    assign w_clear_done = (r_cnt == CW'(TABLE_ENTRIES - 1));
    assign w_rd_idx     = r_cnt[IW-1:0];
    assign w_scan_idx   = IW'(r_cnt - 1'b1);
    assign w_rd_base    = r_rd_data[AW-1:0];
    assign w_rd_len     = r_rd_data[2*AW-1:AW];
    assign w_rd_valid   = r_rd_marks[arat_pkg::MK_VALID];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arat_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (arat_pkg::t_opcode'(s_axis_tuser) == arat_pkg::OP_CLEAR_ALL) begin
                        n_state = arat_pkg::ST_CLEAR;
                    end else if (w_in_addr == '0) begin
                        n_state = arat_pkg::ST_REPLY;
                    end else begin
                        n_state = arat_pkg::ST_SCAN;
                    end
                end
            end
            arat_pkg::ST_CLEAR: begin
                if (w_clear_done) begin
                    n_state = r_op_pend ? arat_pkg::ST_REPLY : arat_pkg::ST_IDLE;
                end
            end
            arat_pkg::ST_SCAN: begin
                if (r_cnt == CW'(TABLE_ENTRIES)) begin
                    n_state = arat_pkg::ST_FINISH;
                end
            end
            arat_pkg::ST_FINISH: begin
                n_state = arat_pkg::ST_REPLY;
            end
            arat_pkg::ST_REPLY: begin
                if (w_load) begin
                    n_state = arat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arat_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = (r_state == arat_pkg::ST_IDLE);
    end

    // result and write-back of the finished operation
    always_comb begin
        n_status    = arat_pkg::STS_OK;
        n_found     = 1'b0;
        n_base      = '0;
        n_len       = '0;
        n_pref      = 1'b1;
        n_ro        = 1'b0;
        n_wo        = 1'b0;
        n_exact     = 1'b0;
        w_dat_we    = 1'b0;
        w_dat_idx   = r_free_idx;
        w_rep_mk_we = 1'b0;
        w_new_marks = r_best_marks;
        if (r_op == arat_pkg::OP_CLEAR_ALL) begin
            n_status = arat_pkg::STS_OK;
        end else if (r_zero) begin
            n_status = arat_pkg::STS_ZERO;
        end else if (r_op == arat_pkg::OP_REGISTER) begin
            if (r_dup || !r_free_vld) begin
                n_status = r_dup ? arat_pkg::STS_DUP : arat_pkg::STS_FULL;
                if (r_hit) begin
                    n_found = 1'b1;
                    n_base  = FB'(r_best_base);
                    n_len   = FB'(r_best_len);
                    n_pref  = r_best_marks[arat_pkg::MK_PREF];
                    n_ro    = r_best_marks[arat_pkg::MK_RO];
                    n_wo    = r_best_marks[arat_pkg::MK_WO];
                    n_exact = (r_addr == r_best_base);
                end
            end else begin
                w_dat_we    = 1'b1;
                w_rep_mk_we = 1'b1;
                w_new_marks = '0;
                w_new_marks[arat_pkg::MK_VALID] = 1'b1;
                if (r_len != '0) begin
                    n_found = 1'b1;
                    n_base  = FB'(r_addr);
                    n_len   = FB'(r_len);
                    n_pref  = 1'b0;
                    n_exact = 1'b1;
                end
            end
        end else if (!r_hit) begin
            n_status = arat_pkg::STS_NOMATCH;
        end else begin
            w_rep_mk_we = 1'b1;
            case (r_op)
                arat_pkg::OP_UNREGISTER: w_new_marks = '0;
                arat_pkg::OP_SET_PREF:   w_new_marks[arat_pkg::MK_PREF] = r_flag;
                arat_pkg::OP_MARK_RO:    w_new_marks[arat_pkg::MK_RO] = 1'b1;
                arat_pkg::OP_MARK_WO:    w_new_marks[arat_pkg::MK_WO] = 1'b1;
                arat_pkg::OP_CLEAR_ADV: begin
                    w_new_marks[arat_pkg::MK_RO] = 1'b0;
                    w_new_marks[arat_pkg::MK_WO] = 1'b0;
                end
                default: w_new_marks = r_best_marks;
            endcase
            n_found = 1'b1;
            n_base  = FB'(r_best_base);
            n_len   = FB'(r_best_len);
            n_exact = (r_addr == r_best_base);
            if (r_op == arat_pkg::OP_UNREGISTER) begin
                n_pref = r_best_marks[arat_pkg::MK_PREF];
                n_ro   = r_best_marks[arat_pkg::MK_RO];
                n_wo   = r_best_marks[arat_pkg::MK_WO];
            end else begin
                n_pref = w_new_marks[arat_pkg::MK_PREF];
                n_ro   = w_new_marks[arat_pkg::MK_RO];
                n_wo   = w_new_marks[arat_pkg::MK_WO];
            end
        end
    end

    // marks write port: clearing pass or write-back
    always_comb begin
        w_mk_we   = 1'b0;
        w_mk_idx  = r_best_idx;
        w_mk_data = w_new_marks;
        if (r_state == arat_pkg::ST_CLEAR) begin
            w_mk_we   = 1'b1;
            w_mk_idx  = w_rd_idx;
            w_mk_data = '0;
        end else if (w_load && w_rep_mk_we) begin
            w_mk_we  = 1'b1;
            w_mk_idx = (r_op == arat_pkg::OP_REGISTER) ? r_free_idx : r_best_idx;
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_load && w_dat_we) begin
            mem_data[w_dat_idx] <= {r_len, r_addr};
        end
        r_rd_data <= mem_data[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_mk_we) begin
            mem_marks[w_mk_idx] <= w_mk_data;
        end
        r_rd_marks <= mem_marks[w_rd_idx];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arat_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_op_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt     <= '0;
                r_op_pend <= 1'b1;
            end else if (r_state == arat_pkg::ST_CLEAR || r_state == arat_pkg::ST_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operands, scan and result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= arat_pkg::t_opcode'(s_axis_tuser);
            r_addr     <= w_in_addr;
            r_len      <= w_in_len;
            r_flag     <= s_axis_tdata[2*FB];
            r_zero     <= (w_in_addr == '0);
            r_best_vld <= 1'b0;
            r_dup      <= 1'b0;
            r_free_vld <= 1'b0;
            r_hit      <= 1'b0;
        end
        if (r_state == arat_pkg::ST_SCAN && r_cnt != '0) begin
            if (w_rd_valid && w_rd_base <= r_addr
                    && (!r_best_vld || w_rd_base > r_best_base)) begin
                r_best_vld   <= 1'b1;
                r_best_base  <= w_rd_base;
                r_best_len   <= w_rd_len;
                r_best_marks <= r_rd_marks;
                r_best_idx   <= w_scan_idx;
            end
            if (w_rd_valid && w_rd_base == r_addr) begin
                r_dup <= 1'b1;
            end
            if (!w_rd_valid && !r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free_idx <= w_scan_idx;
            end
        end
        if (r_state == arat_pkg::ST_FINISH) begin
            r_hit <= r_best_vld && ((r_addr - r_best_base) < r_best_len);
        end
        if (w_load) begin
            r_out_status <= n_status;
            r_out_data   <= {n_exact, n_wo, n_ro, n_pref, n_len, n_base, n_found};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = arat_pkg::OUT_DATA_BITS'(r_out_data);
    assign m_axis_tuser  = r_out_status;

    a_result_from_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("result beat not presented after reply");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second beat accepted while operation in flight");

    a_miss_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (n_status == arat_pkg::STS_NOMATCH || n_status == arat_pkg::STS_ZERO))
        |-> !n_found)
        else $error("miss status with found region");

    a_update_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_rep_mk_we && r_op != arat_pkg::OP_REGISTER) |-> r_hit)
        else $error("marks written back without a hit");

endmodule

// File: tb/tb_address_region_attribute_table.sv
// testbench for the region attribute table: stream driver, result checker and table predictor
`timescale 1ns / 100ps

module tb_address_region_attribute_table;

    localparam int TABLE_ENTRIES = 64;
    localparam int RANDOM_OPS = 1600;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int QUEUE_DEPTH = 3;

    typedef struct {
        arat_pkg::t_opcode opcode;
        logic [47:0]       address;
        logic [47:0]       length;
        logic              flag;
        logic              drain_first;
    } t_region_op;

    typedef struct {
        arat_pkg::t_status status;
        logic              found;
        logic [47:0]       base;
        logic [47:0]       length;
        logic              pref;
        logic              ro;
        logic              wo;
        logic              exact;
    } t_lookup_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // address, region_length, flag_value, zero pad
    logic [arat_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    // opcode
    logic [2:0] s_axis_tuser = arat_pkg::OP_QUERY;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // found, found_base, found_length, is_prefetched, is_read_only, is_write_only, base_exact
    logic [arat_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    // status
    logic [2:0] m_axis_tuser;

    logic [47:0] region_base [TABLE_ENTRIES];
    logic [47:0] region_len [TABLE_ENTRIES];
    logic [arat_pkg::MARK_BITS-1:0] region_marks [TABLE_ENTRIES];

    t_region_op pending_ops[$];
    t_lookup_reply expected_replies[$];
    t_region_op cur_op;
    logic send_busy = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    logic calm = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;
    int random_sent = 0;

    address_region_attribute_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDRESS_BITS (arat_pkg::FIELD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic t_lookup_reply miss_reply(arat_pkg::t_status status);
        t_lookup_reply r;
        r.status = status;
        r.found = 1'b0;
        r.base = '0;
        r.length = '0;
        r.pref = 1'b1;
        r.ro = 1'b0;
        r.wo = 1'b0;
        r.exact = 1'b0;
        return r;
    endfunction

    // highest valid base at or below addr, kept only if addr falls inside it
    function automatic int locate_region(logic [47:0] addr);
        int best;
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (region_marks[i][arat_pkg::MK_VALID] && region_base[i] <= addr) begin
                if (best < 0 || region_base[i] > region_base[best]) best = i;
            end
        end
        if (best >= 0 && (addr - region_base[best]) >= region_len[best]) best = -1;
        return best;
    endfunction

    function automatic t_lookup_reply describe_slot(arat_pkg::t_status status, int slot,
                                                    logic [47:0] addr);
        t_lookup_reply r;
        if (slot < 0) return miss_reply(status);
        r.status = status;
        r.found = 1'b1;
        r.base = region_base[slot];
        r.length = region_len[slot];
        r.pref = region_marks[slot][arat_pkg::MK_PREF];
        r.ro = region_marks[slot][arat_pkg::MK_RO];
        r.wo = region_marks[slot][arat_pkg::MK_WO];
        r.exact = (addr == region_base[slot]);
        return r;
    endfunction

    function automatic t_lookup_reply apply_region_op(t_region_op op);
        t_lookup_reply r;
        int slot;
        int free_slot;
        if (op.opcode == arat_pkg::OP_CLEAR_ALL) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) region_marks[i] = '0;
            return miss_reply(arat_pkg::STS_OK);
        end
        if (op.address == '0) return miss_reply(arat_pkg::STS_ZERO);
        if (op.opcode == arat_pkg::OP_REGISTER) begin
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (region_marks[i][arat_pkg::MK_VALID]) begin
                    if (region_base[i] == op.address)
                        return describe_slot(arat_pkg::STS_DUP, locate_region(op.address),
                                             op.address);
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0)
                return describe_slot(arat_pkg::STS_FULL, locate_region(op.address),
                                     op.address);
            region_base[free_slot] = op.address;
            region_len[free_slot] = op.length;
            region_marks[free_slot] = '0;
            region_marks[free_slot][arat_pkg::MK_VALID] = 1'b1;
            return describe_slot(arat_pkg::STS_OK, locate_region(op.address), op.address);
        end
        slot = locate_region(op.address);
        if (slot < 0) return miss_reply(arat_pkg::STS_NOMATCH);
        case (op.opcode)
            arat_pkg::OP_UNREGISTER: begin
                r = describe_slot(arat_pkg::STS_OK, slot, op.address);
                region_marks[slot] = '0;
                return r;
            end
            arat_pkg::OP_SET_PREF: region_marks[slot][arat_pkg::MK_PREF] = op.flag;
            arat_pkg::OP_MARK_RO: region_marks[slot][arat_pkg::MK_RO] = 1'b1;
            arat_pkg::OP_MARK_WO: region_marks[slot][arat_pkg::MK_WO] = 1'b1;
            arat_pkg::OP_CLEAR_ADV: begin
                region_marks[slot][arat_pkg::MK_RO] = 1'b0;
                region_marks[slot][arat_pkg::MK_WO] = 1'b0;
            end
            default: ;
        endcase
        return describe_slot(arat_pkg::STS_OK, slot, op.address);
    endfunction

    function automatic string reply_text(t_lookup_reply r);
        return $sformatf("sts=%0d hit=%b base=%h len=%h p=%b ro=%b wo=%b ex=%b",
                         r.status, r.found, r.base, r.length, r.pref, r.ro, r.wo, r.exact);
    endfunction

    // stimulus helpers steered by the current table contents
    function automatic int pick_live_slot();
        int live[$];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (region_marks[i][arat_pkg::MK_VALID]) live.insert(live.size(), i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic logic [47:0] window_address();
        return 48'h1000 + 48'($urandom_range(0, 'h1FFFF));
    endfunction

    function automatic logic [47:0] pick_target();
        int r;
        int slot;
        int p;
        r = $urandom_range(99);
        slot = pick_live_slot();
        if (r < 55 && slot >= 0) begin
            p = $urandom_range(9);
            if (p < 3 || region_len[slot] == '0) return region_base[slot];
            if (p < 8) return region_base[slot] + rand48() % region_len[slot];
            return region_base[slot] + region_len[slot] + 48'($urandom_range(0, 3));
        end
        if (r < 85) return window_address();
        if (r < 97) return rand48();
        return '0;
    endfunction

    function automatic logic [47:0] pick_base();
        int r;
        int slot;
        r = $urandom_range(99);
        slot = pick_live_slot();
        if (r < 8 && slot >= 0) return region_base[slot];
        if (r < 10) return '0;
        if (r < 25) return rand48();
        return window_address();
    endfunction

    function automatic logic [47:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return 48'h1;
        if (r < 40) return rand48();
        return 48'($urandom_range(2, 'h3000));
    endfunction

    task automatic queue_op(arat_pkg::t_opcode opcode, logic [47:0] address,
                            logic [47:0] length, logic flag, logic drain_first);
        t_region_op op;
        op.opcode = opcode;
        op.address = address;
        op.length = length;
        op.flag = flag;
        op.drain_first = drain_first;
        while (pending_ops.size() >= QUEUE_DEPTH) @(negedge i_clk);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_random_op(logic drain_first);
        int r;
        arat_pkg::t_opcode opcode;
        r = $urandom_range(99);
        if (r < 22) opcode = arat_pkg::OP_REGISTER;
        else if (r < 30) opcode = arat_pkg::OP_UNREGISTER;
        else if (r < 40) opcode = arat_pkg::OP_SET_PREF;
        else if (r < 50) opcode = arat_pkg::OP_MARK_RO;
        else if (r < 60) opcode = arat_pkg::OP_MARK_WO;
        else if (r < 68) opcode = arat_pkg::OP_CLEAR_ADV;
        else if (r < 99) opcode = arat_pkg::OP_QUERY;
        else opcode = arat_pkg::OP_CLEAR_ALL;
        if (opcode == arat_pkg::OP_REGISTER)
            queue_op(opcode, pick_base(), pick_length(), 1'($urandom_range(1)), drain_first);
        else
            queue_op(opcode, pick_target(), rand48(), 1'($urandom_range(1)), drain_first);
        random_sent++;
    endtask

    // sender: one beat at a time from the pending queue, predicting on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.insert(expected_replies.size(), apply_region_op(cur_op));
                send_busy = 1'b0;
                send_wait = pick_gap();
            end
            if (!send_busy) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain_first && expected_replies.size() > 0)) begin
                    cur_op = pending_ops.pop_front();
                    send_busy = 1'b1;
                end
            end
            s_axis_tvalid <= send_busy;
            s_axis_tdata <= {7'b0, cur_op.flag, cur_op.length, cur_op.address};
            s_axis_tuser <= cur_op.opcode;
        end
    end

    // receiver: random backpressure and compare against the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_reply got;
        t_lookup_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = arat_pkg::t_status'(m_axis_tuser);
                got.found = m_axis_tdata[0];
                got.base = m_axis_tdata[48:1];
                got.length = m_axis_tdata[96:49];
                got.pref = m_axis_tdata[97];
                got.ro = m_axis_tdata[98];
                got.wo = m_axis_tdata[99];
                got.exact = m_axis_tdata[100];
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t unexpected beat: %s", $realtime, reply_text(got));
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser !== want.status || got.found !== want.found ||
                        got.base !== want.base || got.length !== want.length ||
                        got.pref !== want.pref || got.ro !== want.ro ||
                        got.wo !== want.wo || got.exact !== want.exact) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t mismatch\n  exp %s\n  got %s", $realtime,
                                     reply_text(want), reply_text(got));
                    end
                end
                recv_wait = pick_gap();
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_axis_tready <= (recv_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int phase_len;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            region_base[i] = '0;
            region_len[i] = '0;
            region_marks[i] = '0;
        end
        cur_op.opcode = arat_pkg::OP_QUERY;
        cur_op.address = '0;
        cur_op.length = '0;
        cur_op.flag = 1'b0;
        cur_op.drain_first = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_op(arat_pkg::OP_CLEAR_ALL, 48'h0, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h1000, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_REGISTER, 48'h0, 48'h100, 1'b1, 1'b0);
        queue_op(arat_pkg::OP_UNREGISTER, 48'h0, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_REGISTER, 48'h1000, 48'h100, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_REGISTER, 48'h1000, 48'h50, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h1000, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h10FF, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h1100, 48'h0, 1'b0, 1'b0);
        // overlapping region hides the outer one above its own end
        queue_op(arat_pkg::OP_REGISTER, 48'h1080, 48'h10, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h10A0, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_SET_PREF, 48'h1005, 48'h0, 1'b1, 1'b0);
        queue_op(arat_pkg::OP_MARK_RO, 48'h1005, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_MARK_WO, 48'h1005, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h1000, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_SET_PREF, 48'h1005, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_CLEAR_ADV, 48'h1005, 48'h0, 1'b0, 1'b0);
        // zero length region registers fine but never hits
        queue_op(arat_pkg::OP_REGISTER, 48'h2000, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_MARK_RO, 48'h5000, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_REGISTER, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
        queue_op(arat_pkg::OP_UNREGISTER, 48'h1085, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_QUERY, 48'h1085, 48'h0, 1'b0, 1'b0);
        queue_op(arat_pkg::OP_CLEAR_ALL, 48'hFFFF_FFFF_FFFF, 48'h123, 1'b1, 1'b1);
        queue_op(arat_pkg::OP_QUERY, 48'h1000, 48'h0, 1'b0, 1'b0);

        // random phases: mixed traffic and occasional bursts that fill the table
        while (random_sent < RANDOM_OPS) begin
            calm = ($urandom_range(3) == 0);
            if ($urandom_range(9) == 0) begin
                for (int i = 0; i < TABLE_ENTRIES + 8; i++) begin
                    queue_op(arat_pkg::OP_REGISTER, pick_base(), pick_length(),
                             1'($urandom_range(1)), i == 0 && $urandom_range(2) == 0);
                    random_sent++;
                end
            end else begin
                phase_len = $urandom_range(20, 60);
                for (int i = 0; i < phase_len; i++)
                    queue_random_op(i == 0 && $urandom_range(2) == 0);
            end
        end
        calm = 1'b0;

        while (pending_ops.size() != 0 || send_busy || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
